/* design/mrc_pkg.sv */
package mrc_pkg;

    // digit store geometry
    localparam int MAX_DIGITS = 8;
    localparam int DIGIT_BITS = 8;
    localparam int NUM_SLOTS  = 8;
    localparam int IDX_W      = 3;
    localparam int CNT_W      = 4;

    // field widths
    localparam int KEY_W     = 64;
    localparam int KIND_W    = 2;
    localparam int TABLE_W   = 64;
    localparam int SLOT_W    = 8;
    localparam int RADIX_W   = SLOT_W + 1;
    localparam int REM_W     = SLOT_W;
    localparam int CFG_IDX_W = 1;
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = 3;

    localparam logic [RADIX_W-1:0] RADIX_LIMIT = RADIX_W'(1 << DIGIT_BITS);

    typedef logic [DIGIT_BITS-1:0] t_digit;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR   = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_LOAD    = 2'd2,
        KIND_READ    = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIGIT_COUNT = 1'd0,
        REG_RADIX_TABLE = 1'd1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADV,
        S_DIV_GO,
        S_DIV_WAIT,
        S_KEY,
        S_OUT
    } t_state;

    // radix of one digit, from its table byte, limited to the digit width
    function automatic logic [RADIX_W-1:0] radix_of(input logic [TABLE_W-1:0] tbl,
                                                     input logic [IDX_W-1:0] k);
        logic [RADIX_W-1:0] r;
        r = {1'b0, tbl[SLOT_W*k +: SLOT_W]} + RADIX_W'(1);
        if (r > RADIX_LIMIT) begin
            r = RADIX_LIMIT;
        end
        return r;
    endfunction

    // digits in use: zero counts as one, large counts saturate
    function automatic logic [CNT_W-1:0] used_digits(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = c;
        if (n == '0) begin
            n = CNT_W'(1);
        end else if (n > CNT_W'(MAX_DIGITS)) begin
            n = CNT_W'(MAX_DIGITS);
        end
        return n;
    endfunction

endpackage

/* design/mixed_radix_counter.sv */
// mixed-radix odometer, one request in flight, one result per request
// clear and read go straight to the key pass; advance first ripples the carry, one digit per cycle
// load: one division per digit on the shared divider (8 quotient bits per cycle)
// key_out is built by one 64x9 multiply-add per digit, one digit per cycle
// input ready only in idle; a finished result waits in the output register
// synchronous active-low reset: digits zero, digit count 1, radix table 0
module mixed_radix_counter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_we,
    input  logic [mrc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mrc_pkg::TABLE_W-1:0] i_cfg_data,
    // request side
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [63:0]                 i_s_axis_tdata,  // [63:0] key_in
    input  logic [1:0]                  i_s_axis_tuser,  // [1:0] kind
    // result side
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [127:0]                o_m_axis_tdata,  // [63:0] digits_out, [127:64] key_out
    output logic                        o_m_axis_tuser   // [0] in_range
);
    import mrc_pkg::*;

    t_state               r_state;
    t_state               n_state;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_flag;
    logic [KEY_W-1:0]     r_key;
    logic [KEY_W-1:0]     r_lin;
    t_digit               r_digit [NUM_SLOTS];
    logic [CNT_W-1:0]     r_digit_count;
    logic [TABLE_W-1:0]   r_radix_table;
    logic                 r_out_valid;
    logic [127:0]         r_out_data;
    logic                 r_out_flag;

    logic                 w_accept;
    logic                 w_out_free;
    logic [CNT_W-1:0]     w_n;
    logic [IDX_W-1:0]     w_last;
    logic [RADIX_W-1:0]   w_radix;
    logic [RADIX_W-1:0]   w_adv_val;
    logic                 w_adv_fits;
    logic [KEY_W-1:0]     w_mac;
    logic [KEY_W-1:0]     w_packed;
    logic                 w_div_start;
    logic                 w_div_done;
    logic [KEY_W-1:0]     w_div_quo;
    logic [REM_W-1:0]     w_div_rem;

    mrc_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (r_key),
        .i_divisor   (w_radix),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // shared datapath terms for the current digit, and handshake terms
    always_comb begin
        w_n        = used_digits(r_digit_count);
        w_last     = IDX_W'(w_n - CNT_W'(1));
        w_radix    = radix_of(r_radix_table, r_idx);
        w_adv_val  = RADIX_W'(r_digit[r_idx]) + RADIX_W'(1);
        w_adv_fits = (w_adv_val < w_radix);
        w_mac      = r_lin * KEY_W'(w_radix) + KEY_W'(r_digit[r_idx]);
        w_out_free = !r_out_valid || i_m_axis_tready;
        w_accept   = i_s_axis_tvalid && (r_state == S_IDLE);
    end

    // packed digits, unused bytes read zero
    always_comb begin
        w_packed = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (CNT_W'(k) < w_n) begin
                w_packed[SLOT_W*k +: SLOT_W] = SLOT_W'(r_digit[k]);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    case (t_kind'(i_s_axis_tuser))
                        KIND_ADVANCE: n_state = S_ADV;
                        KIND_LOAD:    n_state = S_DIV_GO;
                        default:      n_state = S_KEY;
                    endcase
                end
            end
            S_ADV: begin
                if (w_adv_fits || r_idx == '0) begin
                    n_state = S_KEY;
                end
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = (r_idx == '0) ? S_KEY : S_DIV_GO;
                end
            end
            S_KEY: begin
                if (r_idx == w_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE);
        w_div_start     = (r_state == S_DIV_GO);
    end

    // state, config and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_digit_count <= CNT_W'(1);
            r_radix_table <= '0;
            r_idx         <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_digit[k] <= '0;
            end
        end else begin
            r_state <= n_state;

            // config writes
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_DIGIT_COUNT: r_digit_count <= i_cfg_data[CNT_W-1:0];
                    REG_RADIX_TABLE: r_radix_table <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_key  <= i_s_axis_tdata;
                        r_lin  <= '0;
                        r_flag <= (t_kind'(i_s_axis_tuser) != KIND_ADVANCE);
                        if (t_kind'(i_s_axis_tuser) == KIND_ADVANCE ||
                            t_kind'(i_s_axis_tuser) == KIND_LOAD) begin
                            r_idx <= w_last;
                        end else begin
                            r_idx <= '0;
                        end
                        for (int k = 0; k < NUM_SLOTS; k++) begin
                            if (t_kind'(i_s_axis_tuser) == KIND_CLEAR) begin
                                r_digit[k] <= '0;
                            end else if (t_kind'(i_s_axis_tuser) == KIND_LOAD &&
                                         CNT_W'(k) >= w_n) begin
                                r_digit[k] <= '0;
                            end
                        end
                    end
                end
                // ripple carry from the least significant digit
                S_ADV: begin
                    if (w_adv_fits) begin
                        r_digit[r_idx] <= w_adv_val[DIGIT_BITS-1:0];
                        r_flag         <= 1'b1;
                        r_idx          <= '0;
                    end else begin
                        r_digit[r_idx] <= '0;
                        if (r_idx != '0) begin
                            r_idx <= r_idx - IDX_W'(1);
                        end
                    end
                end
                // one digit per division, least significant first
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_digit[r_idx] <= w_div_rem[DIGIT_BITS-1:0];
                        r_key          <= w_div_quo;
                        if (r_idx == '0) begin
                            r_flag <= (w_div_quo == '0);
                        end else begin
                            r_idx <= r_idx - IDX_W'(1);
                        end
                    end
                end
                // horner accumulation of the key, most significant first
                S_KEY: begin
                    r_lin <= w_mac;
                    if (r_idx != w_last) begin
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {r_lin, w_packed};
                        r_out_flag  <= r_flag;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_flag;

endmodule

/* design/mrc_divider.sv */
module mrc_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mrc_pkg::KEY_W-1:0]   i_dividend,
    input  logic [mrc_pkg::RADIX_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [mrc_pkg::KEY_W-1:0]   o_quotient,
    output logic [mrc_pkg::REM_W-1:0]   o_remainder
);
    import mrc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]     r_quo;
    logic [REM_W-1:0]     r_rem;
    logic [RADIX_W-1:0]   r_div;

    logic [REM_W-1:0]     n_rem;
    logic [DIV_STEPS-1:0] n_qbits;

    // eight restoring steps per cycle, top dividend bits first
    always_comb begin
        logic [RADIX_W-1:0] t;
        n_rem   = r_rem;
        n_qbits = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            t = {n_rem, r_quo[KEY_W-1-j]};
            if (t >= r_div) begin
                n_rem                    = REM_W'(t - r_div);
                n_qbits[DIV_STEPS-1-j]   = 1'b1;
            end else begin
                n_rem = REM_W'(t);
            end
        end
    end

    // dividend shifts out on top while quotient bits shift in below
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[KEY_W-DIV_STEPS-1:0], n_qbits};
                r_rem <= n_rem;
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* tb/tb_mixed_radix_counter.sv */
`timescale 1ns / 100ps

module tb_mixed_radix_counter;
    import mrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 150;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_REQUESTS = 119;

    typedef struct {
        t_kind       kind;
        logic [63:0] key;
    } t_odo_request;

    typedef struct {
        logic [63:0] digits;
        logic [63:0] key;
        logic        fits;
    } t_odo_result;

    // clock, reset and block inputs, all known from time zero
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TABLE_W-1:0]   cfg_data = '0;
    logic                 s_valid  = 1'b0;
    logic [63:0]          s_data   = '0;
    logic [1:0]           s_user   = '0;
    logic                 m_ready  = 1'b0;
    logic                 s_ready;
    logic                 m_valid;
    logic [127:0]         m_data;
    logic                 m_user;

    // requests still to be sent and results still owed by the block
    t_odo_request request_queue [$];
    t_odo_result  expected_odo [$];
    t_odo_request cur_req;

    // shadow copy of the registers and digits
    logic [3:0]   shadow_count = 4'd1;
    logic [63:0]  shadow_table = '0;
    t_digit       shadow_digits [8] = '{default: '0};

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int error_count    = 0;
    int result_count   = 0;
    int miss_count     = 0;
    int setting_count  = 0;
    int kind_count [4] = '{default: 0};

    mixed_radix_counter u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [63:0] key_in
        .i_s_axis_tuser  (s_user),   // [1:0] kind
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [63:0] digits_out, [127:64] key_out
        .o_m_axis_tuser  (m_user)    // [0] in_range
    );

    always #5 clk = ~clk;

    // digits in use: zero counts as one, saturates at the store size
    function automatic int unsigned digits_in_use();
        int unsigned n;
        n = shadow_count;
        if (n == 0) n = 1;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        return n;
    endfunction

    // radix of digit k, limited to what a digit can hold
    function automatic int unsigned radix_at(int unsigned k);
        int unsigned r;
        r = shadow_table[8*k +: 8] + 1;
        if (r > (1 << DIGIT_BITS)) r = 1 << DIGIT_BITS;
        return r;
    endfunction

    function automatic logic [127:0] radix_product();
        logic [127:0] p;
        p = 128'd1;
        for (int k = 0; k < digits_in_use(); k++) p = p * radix_at(k);
        return p;
    endfunction

    // one odometer step on the shadow digits, returns the result it owes
    function automatic t_odo_result odometer_step(t_odo_request req);
        t_odo_result  res;
        int unsigned  n;
        int unsigned  v;
        int unsigned  r;
        logic [63:0]  rem;
        logic [63:0]  d;
        n = digits_in_use();
        res.fits = 1'b1;
        res.digits = '0;
        res.key = '0;
        rem = req.key;
        case (req.kind)
            KIND_CLEAR: begin
                for (int k = 0; k < 8; k++) shadow_digits[k] = '0;
            end
            KIND_ADVANCE: begin
                // carry from the least significant digit up
                res.fits = 1'b0;
                for (int i = n - 1; i >= 0; i--) begin
                    v = shadow_digits[i] + 1;
                    if (v < radix_at(i)) begin
                        shadow_digits[i] = v[DIGIT_BITS-1:0];
                        res.fits = 1'b1;
                        break;
                    end
                    shadow_digits[i] = '0;
                end
            end
            KIND_LOAD: begin
                // unused digits cleared, then repeated division from the bottom
                for (int k = n; k < 8; k++) shadow_digits[k] = '0;
                for (int i = n - 1; i >= 0; i--) begin
                    r = radix_at(i);
                    d = rem % r;
                    shadow_digits[i] = d[DIGIT_BITS-1:0];
                    rem = rem / r;
                end
                res.fits = (rem == 0);
            end
            default: ;
        endcase
        // packed view and linear key of the digits in use
        for (int k = 0; k < n; k++) begin
            d = 64'(shadow_digits[k]);
            res.digits[8*k +: 8] = shadow_digits[k];
            if (k == 0) res.key = d;
            else res.key = res.key * radix_at(k) + d;
        end
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // request driver
    always @(posedge clk) begin
        t_odo_result res;
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                res = odometer_step(cur_req);
                expected_odo.push_back(res);
                kind_count[cur_req.kind]++;
                if (!res.fits) miss_count++;
            end
            if (!s_valid || s_ready) begin
                if (request_queue.size() != 0 &&
                    !(send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)) begin
                    cur_req = request_queue.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= cur_req.key;
                    s_user  <= cur_req.kind;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted down here
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_odo_result want;
        if (!rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                result_count++;
                if (expected_odo.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %h / %b",
                             $time, m_data, m_user);
                    error_count++;
                end else begin
                    want = expected_odo.pop_front();
                    check_field("digits_out", want.digits, m_data[63:0]);
                    check_field("key_out", want.key, m_data[127:64]);
                    check_field("in_range", 64'(want.fits), 64'(m_user));
                end
            end
            m_ready <= (hold_left == 0) &&
                       !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic queue_request(t_kind kind, logic [63:0] key);
        t_odo_request req;
        req.kind = kind;
        req.key = key;
        request_queue.push_back(req);
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (request_queue.size() != 0 || s_valid || expected_odo.size() != 0);
    endtask

    // register write once the block has nothing in flight
    task automatic write_reg(t_reg_idx idx, logic [63:0] val);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DIGIT_COUNT) shadow_count = val[3:0];
        else shadow_table = val;
        setting_count++;
    endtask

    // random request, its key raw, reduced modulo the radix product, at the edge of that product, or small
    task automatic queue_random_request();
        int unsigned  w;
        t_kind        kind;
        logic [63:0]  key;
        logic [127:0] p;
        w = $urandom_range(99);
        if (w < 8) kind = KIND_CLEAR;
        else if (w < 53) kind = KIND_ADVANCE;
        else if (w < 78) kind = KIND_LOAD;
        else kind = KIND_READ;
        key = {$urandom, $urandom};
        p = radix_product();
        case ($urandom_range(3))
            0: ;
            1: key = 64'(128'(key) % p);
            2: begin
                if (p > 128'hFFFF_FFFF_FFFF_FFFF) key = '1;
                else key = 64'(p) - 64'($urandom_range(1));
            end
            default: key = 64'($urandom_range(300));
        endcase
        queue_request(kind, key);
    endtask

    function automatic logic [63:0] random_table(int style);
        logic [63:0] t;
        for (int k = 0; k < 8; k++) begin
            case (style)
                0: t[8*k +: 8] = 8'($urandom);
                1: t[8*k +: 8] = 8'($urandom_range(3));
                2: t[8*k +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
                default: t[8*k +: 8] = 8'($urandom_range(15));
            endcase
        end
        return t;
    endfunction

    // stimulus: directed corners, then random phases under varied flow control
    initial begin
        logic [63:0] count_word;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // single digit of radix one after reset
        queue_request(KIND_READ, 64'd0);
        queue_request(KIND_ADVANCE, 64'd0);
        queue_request(KIND_LOAD, 64'd0);
        queue_request(KIND_LOAD, '1);
        queue_request(KIND_CLEAR, '1);

        // eight digits of radix 256: whole key range
        write_reg(REG_DIGIT_COUNT, 64'd8);
        write_reg(REG_RADIX_TABLE, '1);
        queue_request(KIND_LOAD, '1);
        queue_request(KIND_ADVANCE, 64'd0);
        queue_request(KIND_LOAD, 64'hFFFF_FFFF_FFFF_FFFE);
        queue_request(KIND_ADVANCE, 64'd0);
        queue_request(KIND_READ, 64'd0);

        // digits left above a smaller radix
        write_reg(REG_RADIX_TABLE, 64'h0202_0202_0202_0202);
        queue_request(KIND_READ, 64'd0);
        queue_request(KIND_ADVANCE, 64'd0);
        queue_request(KIND_ADVANCE, 64'd0);

        // digit count zero acts as one
        write_reg(REG_DIGIT_COUNT, 64'd0);
        queue_request(KIND_ADVANCE, 64'd0);
        queue_request(KIND_LOAD, 64'd7);

        // digit count above the store saturates
        write_reg(REG_DIGIT_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_request(KIND_READ, 64'd0);
        queue_request(KIND_LOAD, 64'd6560);
        queue_request(KIND_LOAD, 64'd6561);
        queue_request(KIND_CLEAR, 64'd0);
        queue_request(KIND_READ, 64'd0);

        // radices 3, 4, 5: last setting and wrap
        write_reg(REG_DIGIT_COUNT, 64'd3);
        write_reg(REG_RADIX_TABLE, 64'h0000_0000_0004_0302);
        queue_request(KIND_LOAD, 64'd59);
        queue_request(KIND_ADVANCE, 64'd0);
        queue_request(KIND_LOAD, 64'd60);
        queue_request(KIND_ADVANCE, 64'd0);
        queue_request(KIND_ADVANCE, 64'd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            count_word = {$urandom, $urandom};
            count_word[3:0] = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                         : 4'($urandom_range(1, 8));
            write_reg(REG_DIGIT_COUNT, count_word);
            write_reg(REG_RADIX_TABLE, random_table((p / 4 + p) % 4));
            case (p % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 69; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 69; end
                default: begin send_gap_pct = 19; recv_stall_pct = 19; end
            endcase
            if (p == 0) begin
                @(posedge clk);
                hold_left <= HOLD_CYCLES;
            end
            for (int i = 0; i < PHASE_REQUESTS; i++) queue_random_request();
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests: clear %0d, advance %0d, load %0d, read %0d",
                 kind_count[KIND_CLEAR] + kind_count[KIND_ADVANCE] +
                 kind_count[KIND_LOAD] + kind_count[KIND_READ],
                 kind_count[KIND_CLEAR], kind_count[KIND_ADVANCE],
                 kind_count[KIND_LOAD], kind_count[KIND_READ]);
        $display("%0d results checked, %0d wraps or oversized keys, %0d register writes",
                 result_count, miss_count, setting_count);
        if (error_count == 0 && expected_odo.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
design/mrc_pkg.sv
design/mrc_divider.sv
design/mixed_radix_counter.sv
tb/tb_mixed_radix_counter.sv
